// ===== rtl/core/iss_pkg.sv =====
package iss_pkg;

	localparam logic [2:0] RQ_INS_FRONT = 3'd0;
	localparam logic [2:0] RQ_INS_BACK  = 3'd1;
	localparam logic [2:0] RQ_INS_AT    = 3'd2;
	localparam logic [2:0] RQ_REM_FRONT = 3'd3;
	localparam logic [2:0] RQ_REM_BACK  = 3'd4;
	localparam logic [2:0] RQ_REM_AT    = 3'd5;
	localparam logic [2:0] RQ_DUMP      = 3'd6;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_VALUE   = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_INVALID = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		K_REPORT = 2'd0,
		K_INS    = 2'd1,
		K_REM    = 2'd2,
		K_DUMP   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t   kind;
		status_t status;
	} cmd_ctl_t;

endpackage

// ===== rtl/core/iss_front.sv =====
module iss_front #(
	parameter int CAPACITY   = 32,
	parameter int VALUE_BITS = 32,
	parameter int IDXW       = 5,
	parameter int CW         = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            req_type,
	input  logic [5:0]            position,
	input  logic signed [31:0]    item_value,
	output logic                  cmd_valid,
	input  logic                  cmd_ready,
	output iss_pkg::cmd_ctl_t     cmd_ctl,
	output logic [IDXW-1:0]       cmd_idx,
	output logic [CW-1:0]         cmd_cnt,
	output logic [VALUE_BITS-1:0] cmd_value
);
	import iss_pkg::*;

	localparam int CMPW = (CW > 6) ? CW : 6;

	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   cnt_nxt;
	logic [CMPW-1:0] cnt_w;
	logic [CMPW-1:0] pos_w;
	logic [CMPW-1:0] at_w;
	logic [63:0]     ext_value;

	assign cnt_w     = CMPW'(cnt_q);
	assign pos_w     = CMPW'(position);
	assign ext_value = {{32{item_value[31]}}, item_value};

	// The front keeps its own copy of the fill count, so every request is
	// classified on arrival and the back only executes.
	always_comb begin
		cmd_ctl.kind   = K_REPORT;
		cmd_ctl.status = ST_INVALID;
		at_w           = '0;
		cnt_nxt        = cnt_q;
		unique case (req_type)
			RQ_INS_FRONT, RQ_INS_BACK, RQ_INS_AT: begin
				priority if (req_type == RQ_INS_FRONT) begin
					at_w = '0;
				end else if (req_type == RQ_INS_BACK) begin
					at_w = cnt_w;
				end else begin
					at_w = pos_w;
				end
				priority if (at_w > cnt_w) begin
					cmd_ctl.status = ST_INVALID;
				end else if (cnt_q == CW'(CAPACITY)) begin
					cmd_ctl.status = ST_FULL;
				end else begin
					cmd_ctl.kind   = K_INS;
					cmd_ctl.status = ST_DONE;
					cnt_nxt        = cnt_q + 1'b1;
				end
			end
			RQ_REM_FRONT, RQ_REM_BACK, RQ_REM_AT: begin
				if (cnt_q == '0) begin
					cmd_ctl.status = ST_EMPTY;
				end else begin
					priority if (req_type == RQ_REM_FRONT) begin
						at_w = '0;
					end else if (req_type == RQ_REM_BACK) begin
						at_w = cnt_w - 1'b1;
					end else begin
						at_w = pos_w;
					end
					if (at_w >= cnt_w) begin
						cmd_ctl.status = ST_INVALID;
					end else begin
						cmd_ctl.kind   = K_REM;
						cmd_ctl.status = ST_VALUE;
						cnt_nxt        = cnt_q - 1'b1;
					end
				end
			end
			RQ_DUMP: begin
				if (cnt_q == '0) begin
					cmd_ctl.status = ST_EMPTY;
				end else begin
					cmd_ctl.kind   = K_DUMP;
					cmd_ctl.status = ST_VALUE;
				end
			end
			default: begin
				cmd_ctl.status = ST_INVALID;
			end
		endcase
	end

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign cmd_idx   = at_w[IDXW-1:0];
	assign cmd_cnt   = cnt_q;
	assign cmd_value = ext_value[VALUE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_valid && cmd_ready) begin
			cnt_q <= cnt_nxt;
		end
	end

endmodule

// ===== rtl/core/iss_queue.sv =====
module iss_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/iss_back.sv =====
module iss_back #(
	parameter int CAPACITY   = 32,
	parameter int VALUE_BITS = 32,
	parameter int IDXW       = 5,
	parameter int CW         = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  iss_pkg::cmd_ctl_t     cmd_ctl,
	input  logic [IDXW-1:0]       cmd_idx,
	input  logic [CW-1:0]         cmd_cnt,
	input  logic [VALUE_BITS-1:0] cmd_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic signed [31:0]    out_value,
	output logic                  last_of_run
);
	import iss_pkg::*;

	logic [VALUE_BITS-1:0] cells_q [CAPACITY];
	logic                  dumping_q;
	logic [IDXW-1:0]       didx_q;
	logic [CW-1:0]         dlen_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic signed [31:0]    out_value_q;
	logic                  last_q;
	logic                  out_free;
	logic                  do_cmd;
	logic [IDXW-1:0]       rd_idx;
	logic [VALUE_BITS-1:0] rd_cell;
	logic [63:0]           rd_wide;
	logic                  dump_last;

	assign out_free  = !out_valid_q || out_ready;
	assign cmd_ready = out_free && !dumping_q;
	assign do_cmd    = cmd_valid && cmd_ready;

	assign rd_idx    = dumping_q ? didx_q : cmd_idx;
	assign rd_cell   = cells_q[rd_idx];
	assign rd_wide   = 64'(rd_cell);
	assign dump_last = ((CW'(didx_q) + 1'b1) == dlen_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			dumping_q   <= 1'b0;
			didx_q      <= '0;
			dlen_q      <= '0;
		end else begin
			if (dumping_q && out_free) begin
				out_valid_q <= 1'b1;
				didx_q      <= didx_q + 1'b1;
				if (dump_last) begin
					dumping_q <= 1'b0;
				end
			end else if (do_cmd) begin
				out_valid_q <= 1'b1;
				if (cmd_ctl.kind == K_DUMP && cmd_cnt != CW'(1)) begin
					dumping_q <= 1'b1;
					didx_q    <= IDXW'(1);
					dlen_q    <= cmd_cnt;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dumping_q && out_free) begin
			status_q    <= ST_VALUE;
			out_value_q <= $signed(rd_wide[31:0]);
			last_q      <= dump_last;
		end else if (do_cmd) begin
			status_q <= cmd_ctl.status;
			unique case (cmd_ctl.kind)
				K_REM: begin
					out_value_q <= $signed(rd_wide[31:0]);
					last_q      <= 1'b1;
				end
				K_DUMP: begin
					out_value_q <= $signed(rd_wide[31:0]);
					last_q      <= (cmd_cnt == CW'(1));
				end
				default: begin
					out_value_q <= '0;
					last_q      <= 1'b1;
				end
			endcase
		end
	end

	// Each cell moves by at most one place per operation.
	always_ff @(posedge clk) begin
		if (do_cmd && cmd_ctl.kind == K_INS) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (IDXW'(i) == cmd_idx) begin
					cells_q[i] <= cmd_value;
				end else if (i > 0 && IDXW'(i) > cmd_idx) begin
					cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
				end
			end
		end else if (do_cmd && cmd_ctl.kind == K_REM) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (IDXW'(i) >= cmd_idx) begin
					cells_q[i] <= cells_q[i + 1];
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_value   = out_value_q;
	assign last_of_run = last_q;

endmodule

// ===== rtl/core/indexed_sequence_store_unit.sv =====
// Channel   Transfer when           Payload
// in        in_valid & in_ready     req_type, position, item_value
// out       out_valid & out_ready   status, out_value, last_of_run
//
// Inserts, removals and rejected requests each give one result. A dump of n entries
// gives n results, one per cycle from the cell row when not stalled; the back end
// takes no other request until the dump ends. A result goes through the queue into
// the output register. Reset clears the count; the cell row is not cleared.
// A stalled output holds the back end, and the front stalls once the queue is full.
module indexed_sequence_store_unit #(
	parameter int CAPACITY   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [5:0]         position,
	input  logic signed [31:0] item_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic signed [31:0] out_value,
	output logic               last_of_run
);
	import iss_pkg::*;

	localparam int IDXW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CTLW = $bits(cmd_ctl_t);
	localparam int QW   = CTLW + IDXW + CW + VALUE_BITS;

	logic                  f_valid;
	logic                  f_ready;
	cmd_ctl_t              f_ctl;
	logic [IDXW-1:0]       f_idx;
	logic [CW-1:0]         f_cnt;
	logic [VALUE_BITS-1:0] f_value;
	logic [QW-1:0]         q_push_data;
	logic                  b_valid;
	logic                  b_ready;
	logic [QW-1:0]         q_pop_data;
	cmd_ctl_t              b_ctl;
	logic [IDXW-1:0]       b_idx;
	logic [CW-1:0]         b_cnt;
	logic [VALUE_BITS-1:0] b_value;

	iss_front #(
		.CAPACITY  (CAPACITY),
		.VALUE_BITS(VALUE_BITS),
		.IDXW      (IDXW),
		.CW        (CW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.position  (position),
		.item_value(item_value),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd_ctl   (f_ctl),
		.cmd_idx   (f_idx),
		.cmd_cnt   (f_cnt),
		.cmd_value (f_value)
	);

	assign q_push_data = {f_ctl, f_idx, f_cnt, f_value};

	iss_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (q_push_data),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (q_pop_data)
	);

	assign b_ctl   = cmd_ctl_t'(q_pop_data[QW-1 -: CTLW]);
	assign b_idx   = q_pop_data[CW + VALUE_BITS + IDXW - 1 -: IDXW];
	assign b_cnt   = q_pop_data[CW + VALUE_BITS - 1 -: CW];
	assign b_value = q_pop_data[VALUE_BITS-1:0];

	iss_back #(
		.CAPACITY  (CAPACITY),
		.VALUE_BITS(VALUE_BITS),
		.IDXW      (IDXW),
		.CW        (CW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (b_valid),
		.cmd_ready  (b_ready),
		.cmd_ctl    (b_ctl),
		.cmd_idx    (b_idx),
		.cmd_cnt    (b_cnt),
		.cmd_value  (b_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_value  (out_value),
		.last_of_run(last_of_run)
	);

endmodule

// ===== verif/iss_list_checker.sv =====
`timescale 1ns / 100ps
module iss_list_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [5:0]         position,
	input  logic signed [31:0] item_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [2:0]         status,
	input  logic signed [31:0] out_value,
	input  logic               last_of_run,
	output int                 fail_count,
	output int                 replies_owed,
	output int                 list_size,
	output int                 replies_checked
);
	import iss_pkg::*;

	localparam int SLOTS = 32;

	typedef struct packed {
		status_t     status;
		logic [31:0] value;
		logic        last;
	} reply_t;

	logic [31:0] list_cells [SLOTS];
	int          list_len;
	int          misses;
	int          checked;
	reply_t      replies_due [$];
	reply_t      due;

	function automatic void post_reply(status_t st, logic [31:0] val, logic last);
		reply_t r;
		r.status = st;
		r.value  = val;
		r.last   = last;
		replies_due.push_back(r);
	endfunction

	function automatic status_t insert_at(int at, logic [31:0] val);
		if (at > list_len)
			return ST_INVALID;
		if (list_len >= SLOTS)
			return ST_FULL;
		for (int i = list_len; i > at; i--)
			list_cells[i] = list_cells[i - 1];
		list_cells[at] = val;
		list_len++;
		return ST_DONE;
	endfunction

	function automatic status_t remove_at(int at, output logic [31:0] got);
		got = '0;
		if (list_len == 0)
			return ST_EMPTY;
		if (at >= list_len)
			return ST_INVALID;
		got = list_cells[at];
		for (int i = at; i + 1 < list_len; i++)
			list_cells[i] = list_cells[i + 1];
		list_len--;
		return ST_VALUE;
	endfunction

	function automatic void apply_list_request(logic [2:0] req, logic [5:0] pos,
			logic [31:0] val);
		status_t     st;
		logic [31:0] got;
		got = '0;
		case (req)
			RQ_INS_FRONT: st = insert_at(0, val);
			RQ_INS_BACK:  st = insert_at(list_len, val);
			RQ_INS_AT:    st = insert_at(int'(pos), val);
			RQ_REM_FRONT: st = remove_at(0, got);
			RQ_REM_BACK:  st = remove_at(list_len == 0 ? 0 : list_len - 1, got);
			RQ_REM_AT:    st = remove_at(int'(pos), got);
			RQ_DUMP: begin
				if (list_len == 0) begin
					post_reply(ST_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < list_len; i++)
						post_reply(ST_VALUE, list_cells[i], i == list_len - 1);
				end
				return;
			end
			default:      st = ST_INVALID;
		endcase
		post_reply(st, st == ST_VALUE ? got : 32'd0, 1'b1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			misses = 0;
			checked = 0;
			replies_due.delete();
			fail_count <= 0;
			replies_owed <= 0;
			list_size <= 0;
			replies_checked <= 0;
		end else begin
			if (in_valid && in_ready)
				apply_list_request(req_type, position, item_value);
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$error("result with no request outstanding: status %0d, out_value %0d",
						status, out_value);
					misses++;
				end else begin
					due = replies_due.pop_front();
					checked++;
					if (status !== due.status) begin
						$error("status mismatch: expected %0d, actual %0d", due.status, status);
						misses++;
					end
					if (out_value !== due.value) begin
						$error("out_value mismatch: expected %0d, actual %0d",
							$signed(due.value), out_value);
						misses++;
					end
					if (last_of_run !== due.last) begin
						$error("last_of_run mismatch: expected %0d, actual %0d",
							due.last, last_of_run);
						misses++;
					end
				end
			end
			fail_count <= misses;
			replies_owed <= replies_due.size();
			list_size <= list_len;
			replies_checked <= checked;
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
module tb;
	import iss_pkg::*;

	localparam logic [2:0] RQ_UNUSED   = 3'd7;
	localparam int         SLOTS       = 32;
	localparam int         CYCLE_LIMIT = 500000;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         req_type = '0;
	logic [5:0]         position = '0;
	logic signed [31:0] item_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] out_value;
	logic               last_of_run;

	int fail_count;
	int replies_owed;
	int list_size;
	int replies_checked;
	int sent = 0;
	int peak = 0;
	int cycles = 0;
	int hold_cycles = 0;
	bit quiet = 1'b0;
	bit took_result = 1'b0;
	int fill_mix [4] = '{20, 85, 50, 15};

	indexed_sequence_store_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.position   (position),
		.item_value (item_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_value  (out_value),
		.last_of_run(last_of_run)
	);

	iss_list_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.position       (position),
		.item_value     (item_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.out_value      (out_value),
		.last_of_run    (last_of_run),
		.fail_count     (fail_count),
		.replies_owed   (replies_owed),
		.list_size      (list_size),
		.replies_checked(replies_checked)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("indexed_sequence_store_unit test failed");
			$finish;
		end
	end

	always @(posedge clk)
		took_result <= out_valid && out_ready;

	always @(negedge clk) begin
		if (took_result)
			hold_cycles = quiet ? 0 : $urandom_range(0, 14);
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(logic [2:0] req, logic [5:0] pos, logic [31:0] val);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		position <= pos;
		item_value <= val;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		sent++;
		if (list_size > peak)
			peak = list_size;
	endtask

	task automatic random_request(int fill_pct);
		int         roll;
		logic [2:0] req;
		logic [5:0] pos;
		roll = $urandom_range(0, 99);
		pos = 6'($urandom_range(0, 63));
		if (roll < fill_pct) begin
			case ($urandom_range(0, 2))
				0:       req = RQ_INS_FRONT;
				1:       req = RQ_INS_BACK;
				default: req = RQ_INS_AT;
			endcase
			if ($urandom_range(0, 3) != 0)
				pos = 6'($urandom_range(0, list_size));
		end else if (roll < 92) begin
			case ($urandom_range(0, 2))
				0:       req = RQ_REM_FRONT;
				1:       req = RQ_REM_BACK;
				default: req = RQ_REM_AT;
			endcase
			if (list_size > 0 && $urandom_range(0, 3) != 0)
				pos = 6'($urandom_range(0, list_size - 1));
		end else if (roll < 97) begin
			req = RQ_DUMP;
		end else begin
			req = RQ_UNUSED;
		end
		send_request(req, pos, pick_value());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_request(RQ_DUMP, 6'd0, 32'd0);
		send_request(RQ_REM_FRONT, 6'd0, 32'd0);
		send_request(RQ_REM_BACK, 6'd0, 32'd0);
		send_request(RQ_REM_AT, 6'd63, 32'd0);
		send_request(RQ_INS_AT, 6'd1, 32'd5);
		send_request(RQ_INS_AT, 6'd0, 32'h8000_0000);
		send_request(RQ_INS_BACK, 6'd0, 32'h7fff_ffff);
		send_request(RQ_INS_FRONT, 6'd0, 32'hffff_ffff);
		send_request(RQ_INS_AT, 6'd3, 32'd0);
		send_request(RQ_INS_AT, 6'd63, 32'h1234_5678);
		send_request(RQ_REM_AT, 6'd4, 32'd0);
		send_request(RQ_REM_AT, 6'd1, 32'd0);
		send_request(RQ_DUMP, 6'd0, 32'd0);
		send_request(RQ_UNUSED, 6'd42, 32'h5555_aaaa);
		send_request(RQ_REM_BACK, 6'd0, 32'd0);
		send_request(RQ_REM_FRONT, 6'd0, 32'd0);
		send_request(RQ_REM_FRONT, 6'd0, 32'd0);

		while (list_size < SLOTS)
			random_request(100);

		send_request(RQ_INS_FRONT, 6'd0, 32'hdead_beef);
		send_request(RQ_INS_BACK, 6'd0, 32'hdead_beef);
		send_request(RQ_INS_AT, 6'd10, 32'hdead_beef);
		send_request(RQ_INS_AT, 6'd32, 32'hdead_beef);
		send_request(RQ_INS_AT, 6'd33, 32'hdead_beef);
		send_request(RQ_DUMP, 6'd0, 32'd0);
		send_request(RQ_REM_AT, 6'd31, 32'd0);
		send_request(RQ_REM_AT, 6'd31, 32'd0);

		for (int blk = 0; blk < 4; blk++) begin
			quiet = (blk == 2);
			repeat (25) random_request(fill_mix[blk]);
		end
		quiet = 1'b0;

		in_valid <= 1'b0;
		while (replies_owed != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d requests transferred and %0d results checked", sent, replies_checked);
		$display("peak list occupancy %0d of %0d entries", peak, SLOTS);
		if (fail_count == 0)
			$display("indexed_sequence_store_unit test passed");
		else
			$display("indexed_sequence_store_unit test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/iss_pkg.sv
rtl/core/iss_front.sv
rtl/core/iss_queue.sv
rtl/core/iss_back.sv
rtl/core/indexed_sequence_store_unit.sv
verif/iss_list_checker.sv
verif/tb.sv
